// File: hw/rtl/can_ignition_gateway_fsm_core_defines.svh
// assertion macros shared by the gateway rtl
`ifndef CAN_IGNITION_GATEWAY_FSM_CORE_DEFINES_SVH
`define CAN_IGNITION_GATEWAY_FSM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CIGF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CIGF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cigf_pkg.sv
// types, codes and reset constants of the ignition gateway
package cigf_pkg;

   localparam int CIGF_ID_W      = 29;
   localparam int CIGF_LEN_W     = 4;
   localparam int CIGF_PAY_W     = 64;
   localparam int CIGF_DELAY_W   = 16;
   localparam int CIGF_BLINK_W   = 8;
   localparam int CIGF_CSR_IDX_W = 3;
   localparam int CIGF_CSR_DAT_W = 29;

   // register indexes
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_SHUTDOWN      = 3'd0;
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_LOSS          = 3'd1;
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_MATCH_ID      = 3'd2;
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_BLINK_IDLE    = 3'd3;
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_BLINK_PREIDLE = 3'd4;
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_BLINK_ACTIVE  = 3'd5;
   localparam logic [CIGF_CSR_IDX_W-1:0] CIGF_REG_BLINK_ECHO    = 3'd6;

   // register reset values
   localparam logic [CIGF_DELAY_W-1:0] CIGF_RST_SHUTDOWN      = 16'd30000;
   localparam logic [CIGF_DELAY_W-1:0] CIGF_RST_LOSS          = 16'd200;
   localparam logic [CIGF_ID_W-1:0]    CIGF_RST_MATCH_ID      = 29'h130;
   localparam logic [CIGF_BLINK_W-1:0] CIGF_RST_BLINK_IDLE    = 8'd199;
   localparam logic [CIGF_BLINK_W-1:0] CIGF_RST_BLINK_PREIDLE = 8'd99;
   localparam logic [CIGF_BLINK_W-1:0] CIGF_RST_BLINK_ACTIVE  = 8'd4;
   localparam logic [CIGF_BLINK_W-1:0] CIGF_RST_BLINK_ECHO    = 8'd19;
   localparam logic [CIGF_BLINK_W-1:0] CIGF_BLINK_MAX         = 8'd255;

   // send port codes
   localparam logic [1:0] CIGF_PORT_NONE = 2'd0;
   localparam logic [1:0] CIGF_PORT_HEAD = 2'd1;
   localparam logic [1:0] CIGF_PORT_CAR  = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_PREIDLE = 2'd1,
      MODE_ACTIVE  = 2'd2,
      MODE_ECHO    = 2'd3
   } cigf_mode_type;

   typedef enum logic [1:0] {
      KIND_CAR  = 2'd0,
      KIND_HEAD = 2'd1,
      KIND_FAST = 2'd2,
      KIND_SLOW = 2'd3
   } cigf_kind_type;

   typedef struct packed {
      logic [CIGF_DELAY_W-1:0] shutdown_delay_ticks;
      logic [CIGF_DELAY_W-1:0] loss_delay_ticks;
      logic [CIGF_ID_W-1:0]    match_id;
      logic [CIGF_BLINK_W-1:0] blink_idle;
      logic [CIGF_BLINK_W-1:0] blink_preidle;
      logic [CIGF_BLINK_W-1:0] blink_active;
      logic [CIGF_BLINK_W-1:0] blink_echo;
   } cigf_cfg_type;

   typedef struct packed {
      cigf_kind_type         kind;
      logic [CIGF_ID_W-1:0]  frame_id;
      logic                  id_extended;
      logic [CIGF_LEN_W-1:0] data_length;
      logic [CIGF_PAY_W-1:0] payload;
   } cigf_item_type;

   typedef struct packed {
      logic [1:0]            send_port;
      logic [CIGF_ID_W-1:0]  out_id;
      logic                  out_extended;
      logic [CIGF_LEN_W-1:0] out_length;
      logic [CIGF_PAY_W-1:0] out_payload;
      logic                  led_toggle;
      logic [1:0]            mode_now;
   } cigf_result_type;

endpackage

// File: hw/rtl/cigf_req_if.sv
// request channel: one frame or tick item
interface cigf_req_if;
   import cigf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [CIGF_ID_W-1:0]  frame_id;
   logic                  id_extended;
   logic [CIGF_LEN_W-1:0] data_length;
   logic [CIGF_PAY_W-1:0] payload;

   modport source (output valid, kind, frame_id, id_extended, data_length, payload,
                   input ready);
   modport sink (input valid, kind, frame_id, id_extended, data_length, payload,
                 output ready);
endinterface

// File: hw/rtl/cigf_rsp_if.sv
// response channel: one result item per request item
interface cigf_rsp_if;
   import cigf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            send_port;
   logic [CIGF_ID_W-1:0]  out_id;
   logic                  out_extended;
   logic [CIGF_LEN_W-1:0] out_length;
   logic [CIGF_PAY_W-1:0] out_payload;
   logic                  led_toggle;
   logic [1:0]            mode_now;

   modport source (output valid, send_port, out_id, out_extended, out_length, out_payload,
                   led_toggle, mode_now, input ready);
   modport sink (input valid, send_port, out_id, out_extended, out_length, out_payload,
                 led_toggle, mode_now, output ready);
endinterface

// File: hw/rtl/can_ignition_gateway_fsm_core.sv
// top level of the can ignition gateway
// usage:
//  req_chan carries one item: a car-side frame, a head-unit frame, a fast tick
//  or a slow tick; rsp_chan returns exactly one result item per request item
//  the csr_ port writes the seven timing/match registers; write only while idle
// pipeline:
//  an accepted item lands in the input register; the controller evaluates it
//  against mode, timers and stored frame, and the result register takes the
//  outcome once that register is free or being drained; rsp_chan.valid rises
//  when the result register holds it
// throughput (while results are taken):
//  one item per cycle; the single mode/timer update per item sets that rate
// stall:
//  while the result register is held by the receiver, the input register
//  still fills once, then req_chan.ready drops until the result is taken
// reset:
//  synchronous, active high; mode idle, timers cleared, stored frame invalid,
//  registers back to their defaults, both pipeline registers empty
`include "can_ignition_gateway_fsm_core_defines.svh"

module can_ignition_gateway_fsm_core (
   input  logic                                 clock,
   input  logic                                 reset,
   cigf_req_if.sink                             req_chan,
   cigf_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [cigf_pkg::CIGF_CSR_IDX_W-1:0]  csr_index,
   input  logic [cigf_pkg::CIGF_CSR_DAT_W-1:0]  csr_write_data
);
   import cigf_pkg::*;

   cigf_cfg_type    cfg;
   cigf_item_type   in_item_ff;
   logic            in_valid_ff, in_valid_in;
   cigf_result_type result;
   cigf_result_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            req_take;

   // item moves to the result register when that slot is free or being drained
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff);

   cigf_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cigf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind        <= cigf_kind_type'(req_chan.kind);
         in_item_ff.frame_id    <= req_chan.frame_id;
         in_item_ff.id_extended <= req_chan.id_extended;
         in_item_ff.data_length <= req_chan.data_length;
         in_item_ff.payload     <= req_chan.payload;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.send_port    = rsp_ff.send_port;
   assign rsp_chan.out_id       = rsp_ff.out_id;
   assign rsp_chan.out_extended = rsp_ff.out_extended;
   assign rsp_chan.out_length   = rsp_ff.out_length;
   assign rsp_chan.out_payload  = rsp_ff.out_payload;
   assign rsp_chan.led_toggle   = rsp_ff.led_toggle;
   assign rsp_chan.mode_now     = rsp_ff.mode_now;

   `CIGF_ASSERT_NEXT(a_take_fills_input, clock, reset, req_take, in_valid_ff, "accepted item not held")
   `CIGF_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_item_ff), "input register lost item while blocked")
   `CIGF_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff, "result register empty after advance")
   `CIGF_ASSERT_SAME(a_port_code, clock, reset, rsp_valid_ff, rsp_ff.send_port <= CIGF_PORT_CAR, "undefined send port code")

endmodule

// File: hw/rtl/cigf_cfg.sv
// configuration register file
module cigf_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cigf_pkg::CIGF_CSR_IDX_W-1:0]  csr_index,
   input  logic [cigf_pkg::CIGF_CSR_DAT_W-1:0]  csr_write_data,
   output cigf_pkg::cigf_cfg_type               cfg
);
   import cigf_pkg::*;

   cigf_cfg_type cfg_ff;
   cigf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CIGF_REG_SHUTDOWN:
               cfg_in.shutdown_delay_ticks = csr_write_data[CIGF_DELAY_W-1:0];
            CIGF_REG_LOSS:
               cfg_in.loss_delay_ticks = csr_write_data[CIGF_DELAY_W-1:0];
            CIGF_REG_MATCH_ID:
               cfg_in.match_id = csr_write_data[CIGF_ID_W-1:0];
            CIGF_REG_BLINK_IDLE:
               cfg_in.blink_idle = csr_write_data[CIGF_BLINK_W-1:0];
            CIGF_REG_BLINK_PREIDLE:
               cfg_in.blink_preidle = csr_write_data[CIGF_BLINK_W-1:0];
            CIGF_REG_BLINK_ACTIVE:
               cfg_in.blink_active = csr_write_data[CIGF_BLINK_W-1:0];
            CIGF_REG_BLINK_ECHO:
               cfg_in.blink_echo = csr_write_data[CIGF_BLINK_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shutdown_delay_ticks <= CIGF_RST_SHUTDOWN;
         cfg_ff.loss_delay_ticks     <= CIGF_RST_LOSS;
         cfg_ff.match_id             <= CIGF_RST_MATCH_ID;
         cfg_ff.blink_idle           <= CIGF_RST_BLINK_IDLE;
         cfg_ff.blink_preidle        <= CIGF_RST_BLINK_PREIDLE;
         cfg_ff.blink_active         <= CIGF_RST_BLINK_ACTIVE;
         cfg_ff.blink_echo           <= CIGF_RST_BLINK_ECHO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/cigf_ctrl.sv
// mode controller, timers and stored frame; computes one result per step
`include "can_ignition_gateway_fsm_core_defines.svh"

module cigf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  cigf_pkg::cigf_item_type    item,
   input  cigf_pkg::cigf_cfg_type     cfg,
   output cigf_pkg::cigf_result_type  result
);
   import cigf_pkg::*;

   cigf_mode_type           mode_ff, mode_in, mode_mid;
   logic [CIGF_DELAY_W-1:0] ign_ff, ign_in;
   logic [CIGF_DELAY_W-1:0] loss_ff, loss_in;
   logic [CIGF_BLINK_W-1:0] blink_ff, blink_in;
   logic [CIGF_BLINK_W-1:0] limit;
   logic                    flip;
   logic                    stored_valid_ff;
   logic                    store_hit;
   logic                    id_hit;
   logic [CIGF_PAY_W-1:0]   pay;

   logic [CIGF_ID_W-1:0]    stored_id_ff;
   logic                    stored_ext_ff;
   logic [CIGF_LEN_W-1:0]   stored_len_ff;
   logic [CIGF_PAY_W-1:0]   stored_pay_ff;

   assign id_hit = (item.frame_id == cfg.match_id);

   always_comb begin
      mode_in   = mode_ff;
      mode_mid  = mode_ff;
      ign_in    = ign_ff;
      loss_in   = loss_ff;
      blink_in  = blink_ff;
      store_hit = 1'b0;
      flip      = 1'b0;
      pay       = item.payload;
      result    = '0;

      unique case (mode_ff)
         MODE_IDLE:    limit = cfg.blink_idle;
         MODE_PREIDLE: limit = cfg.blink_preidle;
         MODE_ACTIVE:  limit = cfg.blink_active;
         MODE_ECHO:    limit = cfg.blink_echo;
         default:      limit = cfg.blink_echo;
      endcase

      unique case (item.kind)
         KIND_HEAD: begin
            result.send_port    = CIGF_PORT_CAR;
            result.out_id       = item.frame_id;
            result.out_extended = item.id_extended;
            result.out_length   = item.data_length;
            result.out_payload  = item.payload;
         end
         KIND_CAR: begin
            if (id_hit) begin
               store_hit = 1'b1;
               loss_in   = '0;
               if (mode_ff == MODE_IDLE || mode_ff == MODE_ECHO || item.payload[0]) begin
                  ign_in  = '0;
                  mode_in = MODE_ACTIVE;
               end
               // ignition forced on while active
               if (mode_in == MODE_ACTIVE) begin
                  pay[0] = 1'b1;
               end
            end
            result.send_port    = CIGF_PORT_HEAD;
            result.out_id       = item.frame_id;
            result.out_extended = item.id_extended;
            result.out_length   = item.data_length;
            result.out_payload  = pay;
         end
         KIND_FAST: begin
            flip = (blink_ff >= limit);
            if (flip) begin
               blink_in = '0;
            end else if (blink_ff != CIGF_BLINK_MAX) begin
               blink_in = blink_ff + 1'b1;
            end
            // shutdown timeout first
            if (mode_ff != MODE_IDLE && ign_ff < cfg.shutdown_delay_ticks) begin
               ign_in = ign_ff + 1'b1;
            end
            if (ign_in >= cfg.shutdown_delay_ticks) begin
               if (mode_ff == MODE_ACTIVE) begin
                  mode_mid = MODE_PREIDLE;
               end else if (mode_ff == MODE_ECHO) begin
                  mode_mid = MODE_IDLE;
               end
            end
            // then loss timeout on the resulting mode
            if ((mode_mid == MODE_ACTIVE || mode_mid == MODE_PREIDLE)
                && loss_ff < cfg.loss_delay_ticks) begin
               loss_in = loss_ff + 1'b1;
            end
            mode_in = mode_mid;
            if (loss_in >= cfg.loss_delay_ticks) begin
               if (mode_mid == MODE_ACTIVE) begin
                  mode_in = MODE_ECHO;
               end else if (mode_mid == MODE_PREIDLE) begin
                  mode_in = MODE_IDLE;
               end
            end
            result.led_toggle = flip;
         end
         KIND_SLOW: begin
            if (mode_ff == MODE_ECHO && stored_valid_ff) begin
               result.send_port    = CIGF_PORT_HEAD;
               result.out_id       = stored_id_ff;
               result.out_extended = stored_ext_ff;
               result.out_length   = stored_len_ff;
               result.out_payload  = stored_pay_ff | {{(CIGF_PAY_W-1){1'b0}}, 1'b1};
            end
         end
         default: begin
         end
      endcase

      result.mode_now = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         ign_ff          <= '0;
         loss_ff         <= '0;
         blink_ff        <= '0;
         stored_valid_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         ign_ff   <= ign_in;
         loss_ff  <= loss_in;
         blink_ff <= blink_in;
         if (store_hit) begin
            stored_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_hit) begin
         stored_id_ff  <= item.frame_id;
         stored_ext_ff <= item.id_extended;
         stored_len_ff <= item.data_length;
         stored_pay_ff <= item.payload;
      end
   end

   `CIGF_ASSERT_SAME(a_led_only_fast, clock, reset, step && result.led_toggle, item.kind == KIND_FAST, "led toggle outside fast tick")
   `CIGF_ASSERT_NEXT(a_slow_keeps_mode, clock, reset, step && item.kind == KIND_SLOW, $stable(mode_ff), "slow tick changed mode")
   `CIGF_ASSERT_NEXT(a_match_clears_loss, clock, reset, step && item.kind == KIND_CAR && id_hit, loss_ff == '0 && mode_ff != MODE_IDLE, "matching frame did not clear loss timer")
   `CIGF_ASSERT_SAME(a_echo_needs_store, clock, reset, step && item.kind == KIND_SLOW && result.send_port != CIGF_PORT_NONE, stored_valid_ff && mode_ff == MODE_ECHO, "echo without stored frame")

endmodule
